// ===== hdl/gps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gps_pkg;
  localparam int MaxBreedersDefault = 64;
  localparam int FitW = 17;
  localparam int CntW = 7;
  localparam int LiftMax = 65535;

  localparam logic [1:0] MODE_RANDOM = 2'd0;
  localparam logic [1:0] MODE_IMPURE = 2'd1;
  localparam logic [1:0] MODE_PURE = 2'd2;
  localparam logic [1:0] MODE_TOURN = 2'd3;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_CHANCE = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic [0:0] opcode;
    logic [5:0] slot;
    logic signed [15:0] fitness;
    logic [5:0] father_pick_a;
    logic [5:0] father_pick_b;
    logic [31:0] father_draw;
    logic [5:0] mother_pick_a;
    logic [5:0] mother_pick_b;
    logic [31:0] mother_draw;
  } req_t;

  typedef struct packed {
    logic [5:0] father;
    logic [5:0] mother;
    logic empty_wheel;
    logic bad_request;
  } res_t;

  typedef struct packed {
    logic [1:0] index;
    logic [31:0] data;
  } cfg_t;
endpackage
`default_nettype wire

// ===== hdl/gps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gps_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/gps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/ga_parent_selector_top.sv =====
// A select request returns a result; a load returns no result. A new request is accepted
// once the previous result has been taken. A roulette spin over n breeders makes minimum,
// lift and total passes over the entries, runs a restoring divider for draw mod total and
// walks the wheel. Impure roulette spins one wheel and pure roulette spins two.
// Reset is synchronous and active high; the fitness RAM stays undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module ga_parent_selector_top import gps_pkg::*; #(
  parameter int MaxBreeders = MaxBreedersDefault
) (
  input wire logic clk,
  input wire logic rst,
  gps_if.sink in_ch,
  gps_if.sink cfg,
  gps_if.source out_ch
);
  localparam int AW = $clog2(MaxBreeders);
  localparam int NW = $clog2(MaxBreeders + 1);
  localparam logic [NW-1:0] NMax = NW'(MaxBreeders);

  localparam logic [3:0] S_IDLE = 4'd0, S_MIN = 4'd1, S_LIFT = 4'd2, S_SUM = 4'd3,
    S_DIV = 4'd4, S_WALK = 4'd5, S_TA = 4'd6, S_TB = 4'd7, S_TC = 4'd8,
    S_NEXT = 4'd9, S_OUT = 4'd10;

  logic [3:0] state;
  logic [CntW-1:0] breeder_count;
  logic [1:0] selection_mode;
  logic [31:0] win_limit;
  req_t req;
  logic [NW-1:0] n;
  logic [NW-1:0] idx;
  logic rd_pend;
  logic [AW-1:0] rd_addr;
  logic signed [FitW-1:0] lowest;
  logic [31:0] total, run, rem, quo_unused;
  logic [5:0] dcnt;
  logic [AW-1:0] pos;
  logic mother_phase;
  logic [5:0] father_r, mother_r;
  logic empty;
  logic signed [FitW-1:0] fa_v;
  res_t res;
  logic out_valid;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [FitW-1:0] wdata, rdata;
  gps_ram #(.Width(FitW), .Depth(MaxBreeders)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [NW-1:0] n_live;
  logic [5:0] cur_pick, cur_pick_b;
  logic [31:0] cur_draw;
  logic bad;
  logic signed [FitW-1:0] rs;
  logic signed [FitW:0] lifted;
  logic [32:0] trial;
  logic [31:0] run_sum;

  always_comb begin
    if (32'(breeder_count) > 32'(MaxBreeders)) n_live = NMax;
    else n_live = NW'(breeder_count);
  end

  assign cur_pick = mother_phase ? req.mother_pick_a : req.father_pick_a;
  assign cur_pick_b = mother_phase ? req.mother_pick_b : req.father_pick_b;
  assign cur_draw = mother_phase ? req.mother_draw : req.father_draw;
  assign rs = $signed(rdata);
  assign lifted = {rs[FitW-1], rs} - {lowest[FitW-1], lowest};
  assign trial = {rem, quo_unused[31]} - {1'b0, total};
  assign run_sum = run + 32'(unsigned'(rdata));

  always_comb begin
    bad = ({{(32-6){1'b0}}, req.father_pick_a} >= 32'(n))
       || ({{(32-6){1'b0}}, req.mother_pick_a} >= 32'(n));
    if (selection_mode == MODE_TOURN)
      bad = bad || ({{(32-6){1'b0}}, req.father_pick_b} >= 32'(n))
                || ({{(32-6){1'b0}}, req.mother_pick_b} >= 32'(n));
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(req.slot);
    wdata = FitW'($signed(req.fitness));
    raddr = rd_addr;
    if (state == S_IDLE && in_ch.valid && !out_valid && in_ch.payload.opcode == OP_LOAD
        && {{(32-6){1'b0}}, in_ch.payload.slot} < MaxBreeders) begin
      we = 1'b1;
      waddr = AW'(in_ch.payload.slot);
      wdata = FitW'($signed(in_ch.payload.fitness));
    end else if (state == S_LIFT && rd_pend) begin
      we = 1'b1;
      waddr = AW'(idx - NW'(1));
      wdata = (lifted > (FitW+1)'(LiftMax)) ? FitW'(LiftMax) : FitW'(lifted);
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      breeder_count <= 7'd64;
      selection_mode <= MODE_RANDOM;
      win_limit <= 32'h8000_0000;
      out_valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.payload.index)
          REG_COUNT: breeder_count <= cfg.payload.data[6:0];
          REG_MODE: selection_mode <= cfg.payload.data[1:0];
          REG_CHANCE: win_limit <= cfg.payload.data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && in_ch.payload.opcode == OP_SELECT) begin
            req <= in_ch.payload;
            n <= n_live;
            mother_phase <= 1'b0;
            empty <= 1'b0;
            idx <= '0;
            rd_pend <= 1'b0;
            father_r <= in_ch.payload.father_pick_a;
            mother_r <= in_ch.payload.mother_pick_a;
            state <= S_TC;
          end
        end
        S_TC: begin
          if (bad) begin
            res <= '{father: 6'd0, mother: 6'd0, empty_wheel: 1'b0, bad_request: 1'b1};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (selection_mode == MODE_RANDOM) begin
            state <= S_OUT;
          end else if (selection_mode == MODE_TOURN) begin
            rd_addr <= AW'(cur_pick);
            state <= S_TA;
            rd_pend <= 1'b0;
          end else begin
            idx <= '0;
            rd_addr <= '0;
            rd_pend <= 1'b0;
            state <= S_MIN;
          end
        end
        S_TA: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
            rd_addr <= AW'(cur_pick_b);
          end else begin
            fa_v <= rs;
            rd_pend <= 1'b0;
            state <= S_TB;
          end
        end
        S_TB: begin
          if (!rd_pend) rd_pend <= 1'b1;
          else begin
            rd_pend <= 1'b0;
            if (mother_phase) begin
              mother_r <= (fa_v > rs && req.mother_draw <= win_limit)
                          ? req.mother_pick_a : req.mother_pick_b;
              state <= S_OUT;
            end else begin
              father_r <= (fa_v > rs && req.father_draw <= win_limit)
                          ? req.father_pick_a : req.father_pick_b;
              mother_phase <= 1'b1;
              rd_addr <= AW'(req.mother_pick_a);
              state <= S_TA;
            end
          end
        end
        S_MIN: begin
          if (idx < n) begin
            rd_addr <= AW'(idx + NW'(1));
            idx <= idx + NW'(1);
          end
          rd_pend <= idx < n;
          if (rd_pend) begin
            if (idx == NW'(1) || rs < lowest) lowest <= rs;
          end
          if (rd_pend && idx == n) begin
            idx <= '0;
            rd_addr <= '0;
            rd_pend <= 1'b0;
            state <= S_LIFT;
          end
        end
        S_LIFT: begin
          if (!lowest[FitW-1]) begin
            state <= S_SUM;
            total <= '0;
          end else begin
            if (idx < n) begin
              rd_addr <= AW'(idx + NW'(1));
              idx <= idx + NW'(1);
            end
            rd_pend <= idx < n;
            if (rd_pend && idx == n) begin
              idx <= '0;
              rd_addr <= '0;
              rd_pend <= 1'b0;
              lowest <= '0;
              total <= '0;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (idx < n) begin
            rd_addr <= AW'(idx + NW'(1));
            idx <= idx + NW'(1);
          end
          rd_pend <= idx < n;
          if (rd_pend) total <= total + 32'(unsigned'(rdata));
          if (rd_pend && idx == n) begin
            rd_pend <= 1'b0;
            state <= S_DIV;
            rem <= '0;
            quo_unused <= cur_draw;
            dcnt <= '0;
          end
        end
        S_DIV: begin
          if (total == '0) begin
            empty <= 1'b1;
            if (mother_phase) mother_r <= cur_pick;
            else father_r <= cur_pick;
            state <= S_NEXT;
          end else begin
            if (!trial[32]) rem <= trial[31:0];
            else rem <= {rem[30:0], quo_unused[31]};
            quo_unused <= {quo_unused[30:0], 1'b0};
            dcnt <= dcnt + 6'd1;
            if (dcnt == 6'd31) begin
              pos <= AW'(cur_pick);
              rd_addr <= AW'(cur_pick);
              run <= '0;
              idx <= '0;
              rd_pend <= 1'b0;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (!rd_pend) rd_pend <= 1'b1;
          else begin
            run <= run_sum;
            if (run_sum > rem || idx + NW'(1) == n) begin
              if (mother_phase) mother_r <= (run_sum > rem) ? 6'(pos) : cur_pick;
              else father_r <= (run_sum > rem) ? 6'(pos) : cur_pick;
              rd_pend <= 1'b0;
              state <= S_NEXT;
            end else begin
              idx <= idx + NW'(1);
              pos <= (NW'(pos) + NW'(1) >= n) ? '0 : pos + AW'(1);
              rd_addr <= (NW'(pos) + NW'(1) >= n) ? '0 : pos + AW'(1);
              rd_pend <= 1'b0;
            end
          end
        end
        S_NEXT: begin
          if (selection_mode == MODE_PURE && !mother_phase) begin
            mother_phase <= 1'b1;
            idx <= '0;
            rd_addr <= '0;
            rd_pend <= 1'b0;
            state <= S_MIN;
          end else state <= S_OUT;
        end
        S_OUT: begin
          res <= '{father: father_r, mother: mother_r, empty_wheel: empty,
                   bad_request: 1'b0};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.bad_request) |-> (res.father == 6'd0 && res.mother == 6'd0))
    else $error("bad request with nonzero result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid) else $error("result dropped");
  a_lift_write: assert property (@(posedge clk) disable iff (rst)
    (we && state != S_IDLE) |-> (state == S_LIFT)) else $error("stray RAM write");
`endif
endmodule
`default_nettype wire

// ===== verif/ga_parent_selector_top_tb.sv =====
`timescale 1ns / 1ps
module ga_parent_selector_top_tb;
  import gps_pkg::*;

  localparam int Depth = 64;
  localparam int QuietLimit = 200000;
  localparam int ReqW = $bits(req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;

  gps_if #(.T(req_t)) in_ch();
  gps_if #(.T(cfg_t)) cfg();
  gps_if #(.T(res_t)) out_ch();

  ga_parent_selector_top uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .cfg(cfg.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // Shadow state used to predict each selection.
  int fit_shadow[Depth];
  bit written[Depth];
  int unsigned count_shadow;
  logic [1:0] mode_shadow;
  logic [31:0] chance_shadow;

  res_t pending_pairs[$];
  int mismatches = 0;
  bit timed_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  logic [1:0] mode_shadow_list[4] = '{MODE_RANDOM, MODE_IMPURE, MODE_PURE, MODE_TOURN};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg.valid = 1'b0;
    cfg.payload = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned live_breeders();
    return (count_shadow > Depth) ? Depth : count_shadow;
  endfunction

  function automatic logic [5:0] spin_wheel(logic [5:0] start, logic [31:0] draw,
                                            ref bit empty);
    int unsigned n;
    int lowest;
    int lifted;
    logic [31:0] total;
    logic [31:0] hole;
    logic [31:0] run;
    int unsigned pos;
    n = live_breeders();
    lowest = fit_shadow[0];
    total = 0;
    run = 0;
    pos = start;
    for (int i = 0; i < n; i++) if (fit_shadow[i] < lowest) lowest = fit_shadow[i];
    if (lowest < 0) begin
      for (int i = 0; i < n; i++) begin
        lifted = fit_shadow[i] - lowest;
        fit_shadow[i] = (lifted > LiftMax) ? LiftMax : lifted;
      end
    end
    for (int i = 0; i < n; i++) total += fit_shadow[i];
    if (total == 0) begin
      empty = 1'b1;
      return start;
    end
    hole = draw % total;
    for (int i = 0; i < n; i++) begin
      run += fit_shadow[pos];
      if (run > hole) return pos[5:0];
      pos++;
      if (pos >= n) pos = 0;
    end
    return start;
  endfunction

  function automatic logic [5:0] tournament_winner(logic [5:0] a, logic [5:0] b,
                                                   logic [31:0] draw);
    if (fit_shadow[a] > fit_shadow[b] && draw <= chance_shadow) return a;
    return b;
  endfunction

  function automatic void predict_request(req_t r);
    res_t pair;
    int unsigned n;
    bit bad;
    bit empty;
    n = live_breeders();
    empty = 0;
    if (r.opcode == OP_LOAD) begin
      fit_shadow[r.slot] = r.fitness;
      written[r.slot] = 1'b1;
      return;
    end
    bad = r.father_pick_a >= n || r.mother_pick_a >= n;
    if (mode_shadow == MODE_TOURN) bad = bad || r.father_pick_b >= n || r.mother_pick_b >= n;
    pair = '0;
    if (bad) begin
      pair.bad_request = 1'b1;
    end else begin
      pair.father = r.father_pick_a;
      pair.mother = r.mother_pick_a;
      case (mode_shadow)
        MODE_IMPURE: pair.father = spin_wheel(r.father_pick_a, r.father_draw, empty);
        MODE_PURE: begin
          pair.father = spin_wheel(r.father_pick_a, r.father_draw, empty);
          pair.mother = spin_wheel(r.mother_pick_a, r.mother_draw, empty);
        end
        MODE_TOURN: begin
          pair.father = tournament_winner(r.father_pick_a, r.father_pick_b, r.father_draw);
          pair.mother = tournament_winner(r.mother_pick_a, r.mother_pick_b, r.mother_draw);
        end
        default: ;
      endcase
      pair.empty_wheel = empty;
    end
    pending_pairs.push_back(pair);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", out_ch.payload);
        end else begin
          res_t want;
          want = pending_pairs.pop_front();
          if (out_ch.payload !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected father %0d mother %0d empty %0b bad %0b,",
                        " got father %0d mother %0d empty %0b bad %0b"},
                       want.father, want.mother, want.empty_wheel, want.bad_request,
                       out_ch.payload.father, out_ch.payload.mother,
                       out_ch.payload.empty_wheel, out_ch.payload.bad_request);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit && !timed_out) begin
        timed_out = 1;
        $display("FAILURE");
        $finish;
      end
    end
  end

  // The request stays valid after acceptance until the next one replaces it or
  // the sender goes idle.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(r);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.payload <= '{index: idx, data: value};
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_COUNT: count_shadow = value[6:0];
      REG_MODE: mode_shadow = value[1:0];
      REG_CHANCE: chance_shadow = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_slot(logic [5:0] s, logic signed [15:0] f);
    req_t r;
    r = req_t'(ReqW'({$urandom, $urandom, $urandom, $urandom}));
    r.opcode = OP_LOAD;
    r.slot = s;
    r.fitness = f;
    send_request(r);
  endtask

  // Picks stay on written slots; out-of-range picks test the bad request path.
  function automatic logic [5:0] random_pick();
    int unsigned n;
    logic [5:0] p;
    n = live_breeders();
    if ($urandom_range(19) == 0) begin
      p = 6'($urandom);
      if (written[p]) return p;
    end
    return (n == 0) ? 6'd0 : 6'($urandom_range(n - 1));
  endfunction

  function automatic logic [31:0] random_draw();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF - $urandom_range(3);
      1: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic select_pair(logic [5:0] fa, logic [5:0] fb, logic [31:0] fd,
                             logic [5:0] ma, logic [5:0] mb, logic [31:0] md);
    req_t r;
    r = req_t'(ReqW'({$urandom, $urandom, $urandom, $urandom}));
    r.opcode = OP_SELECT;
    r.father_pick_a = fa;
    r.father_pick_b = fb;
    r.father_draw = fd;
    r.mother_pick_a = ma;
    r.mother_pick_b = mb;
    r.mother_draw = md;
    send_request(r);
  endtask

  task automatic random_select();
    select_pair(random_pick(), random_pick(), random_draw(),
                random_pick(), random_pick(), random_draw());
  endtask

  task automatic fill_store(int kind);
    for (int s = 0; s < Depth; s++) begin
      case (kind)
        0: load_slot(s[5:0], 16'($urandom_range(200)));
        1: load_slot(s[5:0], 16'($urandom));
        2: load_slot(s[5:0], 16'sd0);
        default: load_slot(s[5:0], (s % 2) ? 16'sh7FFF : -16'sh8000);
      endcase
    end
  endtask

  task automatic test_directed();
    write_register(REG_COUNT, 32'd64);
    write_register(REG_MODE, 32'(MODE_RANDOM));
    write_register(REG_CHANCE, 32'h8000_0000);
    fill_store(3);
    select_pair(6'd63, 6'd0, 32'd0, 6'd0, 6'd63, 32'hFFFF_FFFF);
    drain_results();
    foreach (mode_shadow_list[i]) begin
      write_register(REG_MODE, 32'(mode_shadow_list[i]));
      select_pair(6'd0, 6'd1, 32'd0, 6'd63, 6'd62, 32'hFFFF_FFFF);
      select_pair(6'd1, 6'd0, 32'd5, 6'd2, 6'd3, 32'd123456);
      drain_results();
    end
    write_register(REG_COUNT, 32'd2);
    write_register(REG_MODE, 32'(MODE_TOURN));
    select_pair(6'd1, 6'd2, 32'd0, 6'd0, 6'd1, 32'd0);
    select_pair(6'd0, 6'd1, 32'd0, 6'd2, 6'd1, 32'd0);
    drain_results();
    write_register(REG_COUNT, 32'd0);
    select_pair(6'd0, 6'd0, 32'd0, 6'd0, 6'd0, 32'd0);
    drain_results();
    write_register(REG_COUNT, 32'd127);
    write_register(REG_MODE, 32'(MODE_PURE));
    fill_store(2);
    select_pair(6'd5, 6'd0, 32'd9, 6'd63, 6'd0, 32'd1);
    drain_results();
  endtask

  task automatic test_random_phase(int items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) begin
      if (k % 75 == 0) begin
        drain_results();
        write_register(REG_MODE, $urandom_range(3));
        case ($urandom_range(3))
          0: write_register(REG_COUNT, 32'd1);
          1: write_register(REG_COUNT, 32'd64);
          default: write_register(REG_COUNT, $urandom_range(2, 64));
        endcase
        case ($urandom_range(2))
          0: write_register(REG_CHANCE, 32'd0);
          1: write_register(REG_CHANCE, 32'hFFFF_FFFF);
          default: write_register(REG_CHANCE, $urandom);
        endcase
      end
      if ($urandom_range(3) == 0) load_slot(6'($urandom), 16'($urandom_range(3) == 0 ?
                                             $urandom : $urandom_range(60)));
      else random_select();
    end
    drain_results();
  endtask

  initial begin
    count_shadow = 64;
    mode_shadow = MODE_RANDOM;
    chance_shadow = 32'h8000_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    fill_store(0);
    test_random_phase(340, 23, 79);
    fill_store(1);
    test_random_phase(340, 79, 23);
    fill_store(0);
    test_random_phase(340, 0, 0);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
